### src/elpf_pkg.sv
// ----------------------------------------------------------------------------
// elpf_pkg
// Shared widths, constants and types of the exponential low-pass filter.
// ----------------------------------------------------------------------------
package elpf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 8;
    localparam int AVG_W    = 26;
    localparam int SUM_W    = AVG_W + WEIGHT_W;
    localparam int SCALE_W  = 10;
    localparam int SCALE    = 1000;
    localparam int ITER     = AVG_W;
    localparam int CNT_W    = $clog2(ITER);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [AVG_W-1:0]    avg_t;
    typedef logic [SUM_W-1:0]    sum_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

### src/elpf_mac.sv
// ----------------------------------------------------------------------------
// elpf_mac
// Weighted sum: weight times previous average plus scaled sample.
// ----------------------------------------------------------------------------
module elpf_mac
    import elpf_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  weight_t weight,
    input  avg_t    avg,
    input  sample_t sample,
    output sum_t    sum
);

    sum_t product_reg;
    avg_t offset_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= SUM_W'(weight) * SUM_W'(avg);
            offset_reg  <= AVG_W'(sample) * AVG_W'(SCALE);
        end
    end

    assign sum = product_reg + SUM_W'(offset_reg);

endmodule

### src/elpf_wdiv.sv
// ----------------------------------------------------------------------------
// elpf_wdiv
// Bit-serial restoring divider by weight plus one, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module elpf_wdiv
    import elpf_pkg::*;
(
    input  logic      aclk,
    input  div_ctrl_t ctrl,
    input  sum_t      sum,
    input  weight_t   weight,
    output logic      qbit,
    output avg_t      quotient
);

    logic [WEIGHT_W-1:0] rem_reg;
    logic [WEIGHT_W-1:0] rem_next;
    avg_t                dividend_reg;
    avg_t                quo_reg;
    logic [WEIGHT_W:0]   trial;
    logic [WEIGHT_W:0]   divisor;
    logic [WEIGHT_W:0]   diff;

    assign divisor  = {1'b0, weight} + (WEIGHT_W+1)'(1);
    assign trial    = {rem_reg, dividend_reg[AVG_W-1]};
    assign qbit     = (trial >= divisor);
    assign diff     = trial - divisor;
    assign rem_next = qbit ? diff[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg      <= sum[SUM_W-1 -: WEIGHT_W];
            dividend_reg <= sum[AVG_W-1:0];
        end else if (ctrl.step) begin
            rem_reg      <= rem_next;
            dividend_reg <= {dividend_reg[AVG_W-2:0], 1'b0};
            quo_reg      <= {quo_reg[AVG_W-2:0], qbit};
        end
    end

endmodule

### src/elpf_kdiv.sv
// ----------------------------------------------------------------------------
// elpf_kdiv
// Bit-serial divider by the scale constant, fed MSB first by the weight divider.
// ----------------------------------------------------------------------------
module elpf_kdiv
    import elpf_pkg::*;
(
    input  logic      aclk,
    input  div_ctrl_t ctrl,
    input  logic      bit_in,
    output sample_t   quotient
);

    logic [SCALE_W-1:0] rem_reg;
    logic [SCALE_W-1:0] rem_next;
    sample_t            quo_reg;
    logic [SCALE_W:0]   trial;
    logic [SCALE_W:0]   diff;
    logic               qbit;

    assign trial    = {rem_reg, bit_in};
    assign qbit     = (trial >= (SCALE_W+1)'(SCALE));
    assign diff     = trial - (SCALE_W+1)'(SCALE);
    assign rem_next = qbit ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
    assign quotient = quo_reg;

    // quotient never exceeds 16 bits, so upper bits falling off are zero
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SAMPLE_W-2:0], qbit};
        end
    end

endmodule

### src/exponential_low_pass_filter_unit.sv
// ----------------------------------------------------------------------------
// exponential_low_pass_filter_unit
// Exponential moving average of 16-bit samples, average kept scaled by 1000.
// ----------------------------------------------------------------------------
// One sample is in work at a time. After its transfer the unit steps through
// the weight multiply, the load of the sum, the bit-serial divider by weight
// plus one (which feeds its quotient bits straight into a chained bit-serial
// divider by 1000), the post of the result into the output register, and a
// return to idle where the next transfer is taken. The output register holds
// a result while the next sample is taken; a result not yet taken when the
// following one is done stalls the divider hand-off. The weight register is
// written whenever cfg_we is high.
module exponential_low_pass_filter_unit
    import elpf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [15:0]   s_sample,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [15:0]   m_filtered
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    weight_t          weight_reg;
    sample_t          sample_reg;
    avg_t             avg_reg;
    logic             m_valid_reg, m_valid_next;
    sample_t          m_filtered_reg;

    div_ctrl_t ctrl;
    logic      mac_en;
    logic      post;
    sum_t      sum;
    logic      qbit;
    avg_t      avg_new;
    sample_t   filt_new;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;
    assign mac_en     = (state_reg == ST_MUL);
    assign ctrl.load  = (state_reg == ST_LOAD);
    assign ctrl.step  = (state_reg == ST_DIV);
    assign post       = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    elpf_mac u_mac (
        .aclk   (aclk),
        .en     (mac_en),
        .weight (weight_reg),
        .avg    (avg_reg),
        .sample (sample_reg),
        .sum    (sum)
    );

    elpf_wdiv u_wdiv (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .sum      (sum),
        .weight   (weight_reg),
        .qbit     (qbit),
        .quotient (avg_new)
    );

    elpf_kdiv u_kdiv (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .bit_in   (qbit),
        .quotient (filt_new)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_DIV;
                count_next = '0;
            end
            ST_DIV: begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(ITER-1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (post) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            weight_reg  <= '0;
            avg_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                weight_reg <= cfg_wdata;
            end
            if (post) begin
                avg_reg <= avg_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
        end
        if (post) begin
            m_filtered_reg <= filt_new;
        end
    end

endmodule

### src/elpf_checker.sv
// ----------------------------------------------------------------------------
// elpf_checker
// Port-level checks of the filter unit, bound to the top level.
// ----------------------------------------------------------------------------
module elpf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_filtered
);

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered))
        else $error("stalled result changed");

    // one sample in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer while busy");

    // a new result comes only out of a busy period
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without work in progress");

endmodule

bind exponential_low_pass_filter_unit elpf_checker u_elpf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_filtered (m_filtered)
);

### test/exponential_low_pass_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// exponential_low_pass_filter_unit_tb
// Self-checking testbench for the exponential low-pass filter unit.
// Every sample transfer is run through a local moving-average model that
// predicts the filtered output. Results are checked in order against that
// prediction while the sender works in random bursts and the receiver stalls
// on its own pattern, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module exponential_low_pass_filter_unit_tb
    import elpf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 400;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [7:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    sample_t   s_sample;
    logic      m_valid;
    logic      m_ready;
    sample_t   m_filtered;

    // model state
    weight_t   cur_weight;
    avg_t      scaled_avg;
    sample_t   filtered_q[$];

    int        fail_count;
    int        hold_reqs;
    int        hold_served;

    exponential_low_pass_filter_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void advance_average(input sample_t s);
        logic [63:0] sum;
        logic [63:0] w;
        w   = {56'd0, cur_weight};
        sum = w * {38'd0, scaled_avg} + 64'(SCALE) * {48'd0, s};
        scaled_avg = avg_t'(sum / (w + 64'd1));
        filtered_q.push_back(sample_t'({38'd0, scaled_avg} / 64'(SCALE)));
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return sample_t'($urandom_range(0, 1500));
            3: return sample_t'($urandom_range(64000, 65535));
            default: return sample_t'($urandom);
        endcase
    endfunction

    // all tasks start and end on a rising edge
    task automatic send_sample(input sample_t s);
        s_valid  <= 1'b1;
        s_sample <= s;
        do @(posedge aclk); while (s_ready !== 1'b1);
        advance_average(s);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_weight(input weight_t w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_weight = w;
    endtask

    task automatic send_bursts(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_sample(rand_sample());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 40));
        end
    endtask

    task automatic test_passthrough();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'd999);
        send_sample(16'd1000);
        send_sample(16'hFFFF);
    endtask

    task automatic test_weight_extremes();
        // average sits at its maximum here, so weight 255 gives the widest sum
        write_weight(8'd255);
        repeat (3) send_sample(16'hFFFF);
        repeat (2) send_sample(16'h0000);
        write_weight(8'd1);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h8000);
        write_weight(8'd0);
        send_sample(16'h7FFF);
    endtask

    task automatic test_backpressure();
        write_weight(8'd3);
        hold_reqs++;
        @(posedge aclk);
        repeat (12) send_sample(rand_sample());
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        repeat (5) send_sample(rand_sample());
        wait_drained();
        repeat (5) send_sample(rand_sample());
    endtask

    task automatic test_random();
        weight_t plan[6];
        plan[0] = 8'd255;
        plan[1] = 8'd0;
        plan[2] = 8'd1;
        plan[3] = weight_t'($urandom);
        plan[4] = 8'd254;
        plan[5] = weight_t'($urandom);
        foreach (plan[i]) begin
            write_weight(plan[i]);
            send_bursts(70);
        end
    endtask

    // receiver: random ready pattern, with a long hold-off on request
    initial begin : receiver
        int mode;
        int seg_left;
        int held;
        mode     = 0;
        seg_left = 0;
        held     = 0;
        m_ready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_served) begin
                m_ready <= 1'b0;
                held++;
                if (held >= LONG_HOLD) begin
                    held = 0;
                    hold_served++;
                end
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(5, 80);
                end
                seg_left--;
                case (mode)
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin : check_result
        sample_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (filtered_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transfer: filtered %0d", m_filtered);
            end else begin
                want = filtered_q.pop_front();
                if (m_filtered !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: filtered expected %0d actual %0d",
                                 want, m_filtered);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 8'd0;
        s_valid     = 1'b0;
        s_sample    = 16'd0;
        cur_weight  = 8'd0;
        scaled_avg  = '0;
        fail_count  = 0;
        hold_reqs   = 0;
        hold_served = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_weight_extremes();
        test_backpressure();
        test_pause_until_drained();
        test_random();

        wait_drained();
        repeat (100) @(posedge aclk);
        if (filtered_q.size() != 0)
            fail_count++;
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
